// File: rtl/biv_pkg.sv
`timescale 1ns / 1ps

package biv_pkg;

  localparam int unsigned LEN_W  = 21;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned IDX_W  = 3;

  localparam logic [WORD_W-1:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [WORD_W-1:0] CRC_INIT  = 32'hFFFF_FFFF;
  localparam logic [LEN_W-1:0]  COUNT_MAX = 21'h1F_FFFF;

  // byte positions of the two captured little-endian words
  localparam logic [LEN_W-1:0] STACK_END = 21'd4;
  localparam logic [LEN_W-1:0] ENTRY_END = 21'd8;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_EXP_LEN   = 3'd0,
    REG_EXP_CRC   = 3'd1,
    REG_STACK_LO  = 3'd2,
    REG_STACK_HI  = 3'd3,
    REG_APP_START = 3'd4,
    REG_MANIFEST  = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_SIZE   = 3'd1,
    ST_LEN_MISM   = 3'd2,
    ST_CRC_BAD    = 3'd3,
    ST_STACK_BAD  = 3'd4,
    ST_ENTRY_BAD  = 3'd5
  } status_t;

  typedef struct packed {
    logic [LEN_W-1:0]  expected_length;
    logic [WORD_W-1:0] expected_crc;
    logic [WORD_W-1:0] stack_low;
    logic [WORD_W-1:0] stack_high;
    logic [WORD_W-1:0] app_start;
    logic [WORD_W-1:0] manifest_addr;
  } cfg_t;

  // image summary taken at the last beat
  typedef struct packed {
    logic [WORD_W-1:0] crc;
    logic [LEN_W-1:0]  count;
    logic [WORD_W-1:0] stack_word;
    logic [WORD_W-1:0] entry_word;
  } snap_t;

  // reflected CRC-32, one byte, bit-serial form unrolled
  function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] c,
                                                 input logic [7:0] b);
    logic [WORD_W-1:0] x;
    x = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage

// File: rtl/biv_accum.sv
`timescale 1ns / 1ps

module biv_accum (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        data_byte,
  input  logic              last,
  output biv_pkg::snap_t    snap
);

  logic [biv_pkg::WORD_W-1:0] crc_r, crc_nxt;
  logic [biv_pkg::LEN_W-1:0]  count_r, count_nxt;
  logic [biv_pkg::WORD_W-1:0] stack_r, stack_nxt;
  logic [biv_pkg::WORD_W-1:0] entry_r, entry_nxt;
  logic [4:0]                 lane_sh;

  assign lane_sh = {count_r[1:0], 3'b000};

  always_comb begin
    stack_nxt = stack_r;
    entry_nxt = entry_r;
    if (count_r < biv_pkg::STACK_END) begin
      stack_nxt[lane_sh +: 8] = stack_r[lane_sh +: 8] | data_byte;
    end else if (count_r < biv_pkg::ENTRY_END) begin
      entry_nxt[lane_sh +: 8] = entry_r[lane_sh +: 8] | data_byte;
    end
    crc_nxt   = biv_pkg::crc_byte(crc_r, data_byte);
    count_nxt = (count_r < biv_pkg::COUNT_MAX) ? count_r + 21'd1 : count_r;
  end

  assign snap.crc        = crc_nxt ^ biv_pkg::CRC_INIT;
  assign snap.count      = count_nxt;
  assign snap.stack_word = stack_nxt;
  assign snap.entry_word = entry_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= biv_pkg::CRC_INIT;
      count_r <= '0;
      stack_r <= '0;
      entry_r <= '0;
    end else if (fire) begin
      if (last) begin
        crc_r   <= biv_pkg::CRC_INIT;
        count_r <= '0;
        stack_r <= '0;
        entry_r <= '0;
      end else begin
        crc_r   <= crc_nxt;
        count_r <= count_nxt;
        stack_r <= stack_nxt;
        entry_r <= entry_nxt;
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    fire && last |=> count_r == '0 && crc_r == biv_pkg::CRC_INIT)
    else $error("accumulator not cleared after last beat");

endmodule

// File: rtl/biv_judge.sv
`timescale 1ns / 1ps

module biv_judge #(
  parameter int unsigned MAX_IMAGE_BYTES = 1048576
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  biv_pkg::cfg_t               cfg,
  input  logic                        load,
  input  biv_pkg::snap_t              snap,
  output logic                        busy,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  out_status,
  output logic [biv_pkg::WORD_W-1:0]  out_computed_crc,
  output logic [biv_pkg::WORD_W-1:0]  out_stack_word,
  output logic [biv_pkg::WORD_W-1:0]  out_entry_word
);

  localparam logic [biv_pkg::WORD_W-1:0] MaxLen = biv_pkg::WORD_W'(MAX_IMAGE_BYTES);

  logic               s1_valid_r;
  biv_pkg::snap_t     s1_r;
  logic               out_valid_r;
  biv_pkg::status_t   status_r, status_nxt;
  biv_pkg::snap_t     res_r;
  logic               out_load;

  logic                       bad_size, stack_bad, entry_bad;
  logic [biv_pkg::WORD_W-1:0] entry_addr;
  logic [biv_pkg::WORD_W:0]   app_end;

  assign out_load = !out_valid_r || !out_stall;
  assign busy     = s1_valid_r && !out_load;

  assign entry_addr = {s1_r.entry_word[biv_pkg::WORD_W-1:1], 1'b0};
  assign app_end    = {1'b0, cfg.app_start} + {12'd0, cfg.expected_length};

  always_comb begin
    bad_size  = (cfg.expected_length == '0) ||
                ({11'd0, cfg.expected_length} > MaxLen);
    stack_bad = (s1_r.stack_word < cfg.stack_low) ||
                (s1_r.stack_word > cfg.stack_high) ||
                (s1_r.stack_word[2:0] != 3'd0);
    entry_bad = (entry_addr < cfg.app_start) ||
                ({1'b0, entry_addr} >= app_end) ||
                (entry_addr >= cfg.manifest_addr) ||
                !s1_r.entry_word[0];
    if (bad_size) begin
      status_nxt = biv_pkg::ST_BAD_SIZE;
    end else if (s1_r.count != cfg.expected_length) begin
      status_nxt = biv_pkg::ST_LEN_MISM;
    end else if (s1_r.crc != cfg.expected_crc) begin
      status_nxt = biv_pkg::ST_CRC_BAD;
    end else if (stack_bad) begin
      status_nxt = biv_pkg::ST_STACK_BAD;
    end else if (entry_bad) begin
      status_nxt = biv_pkg::ST_ENTRY_BAD;
    end else begin
      status_nxt = biv_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        s1_valid_r <= 1'b1;
      end else if (out_load) begin
        s1_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_r <= snap;
    end
    if (out_load && s1_valid_r) begin
      status_r <= status_nxt;
      res_r    <= s1_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_computed_crc = res_r.crc;
  assign out_stack_word   = res_r.stack_word;
  assign out_entry_word   = res_r.entry_word;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !load)
    else $error("summary stage overwritten while held");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_load |=> out_valid_r)
    else $error("summary lost on its way to the output register");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !s1_valid_r && !out_valid_r)
    else $error("pipeline not empty after reset");

endmodule

// File: rtl/boot_image_verifier_unit.sv
// Result path: the last beat loads the summary register, then the output register.
// Throughput: one image byte per cycle unless in_stall holds it; the CRC byte update,
//   counter and word capture all sit in the accumulator stage, the checks in the next one.
// Reset (rst_n, synchronous, active low): config registers go to zero, CRC to all ones,
//   count and captured words to zero, both pipeline stages empty. No clearing pass.
`timescale 1ns / 1ps

module boot_image_verifier_unit #(
  parameter int unsigned MAX_IMAGE_BYTES = 1048576
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration write port
  input  logic                        cfg_wr_en,
  input  logic [biv_pkg::IDX_W-1:0]   cfg_index,
  input  logic [biv_pkg::WORD_W-1:0]  cfg_data,
  // image byte beats
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_last,
  // result beats
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  out_status,
  output logic [biv_pkg::WORD_W-1:0]  out_computed_crc,
  output logic [biv_pkg::WORD_W-1:0]  out_stack_word,
  output logic [biv_pkg::WORD_W-1:0]  out_entry_word
);

  biv_pkg::cfg_t  cfg_r;
  biv_pkg::snap_t snap;
  logic           in_fire;
  logic           judge_busy;

  // Config registers. Indexes past the list are dropped; expected_length keeps
  // only its low 21 bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        biv_pkg::REG_EXP_LEN:   cfg_r.expected_length <= cfg_data[biv_pkg::LEN_W-1:0];
        biv_pkg::REG_EXP_CRC:   cfg_r.expected_crc    <= cfg_data;
        biv_pkg::REG_STACK_LO:  cfg_r.stack_low       <= cfg_data;
        biv_pkg::REG_STACK_HI:  cfg_r.stack_high      <= cfg_data;
        biv_pkg::REG_APP_START: cfg_r.app_start       <= cfg_data;
        biv_pkg::REG_MANIFEST:  cfg_r.manifest_addr   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Every beat is taken unless the summary stage is full and the output
  // register cannot drain it this cycle. Non-last beats only touch the
  // accumulator, but holding them too keeps the stall simple.
  assign in_stall = judge_busy;
  assign in_fire  = in_valid && !in_stall;

  // Running CRC, saturating byte count and capture of the first two words.
  // It hands over the summary including the current byte and clears itself
  // on the last beat.
  biv_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .data_byte (in_data_byte),
    .last      (in_last),
    .snap      (snap)
  );

  // Summary register, prioritized checks, then the output register.
  biv_judge #(
    .MAX_IMAGE_BYTES (MAX_IMAGE_BYTES)
  ) u_judge (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .load             (in_fire && in_last),
    .snap             (snap),
    .busy             (judge_busy),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_computed_crc (out_computed_crc),
    .out_stack_word   (out_stack_word),
    .out_entry_word   (out_entry_word)
  );

endmodule

// File: sim/tb_boot_image_verifier_unit.sv
`timescale 1ns / 1ps

// Streams firmware images into the verifier one byte per beat. A shadow of
// the CRC-32, byte counter and captured vector words runs on every accepted
// beat. On each last beat it records the verdict that the block must return,
// and every result beat is compared field by field against the oldest one.
module tb_boot_image_verifier_unit;

  localparam int unsigned IMAGE_MAX = 1048576;
  // wait allowance for a result after the last beat; settle adds margin on top of that
  localparam int PIPE_LAT = 2;
  localparam logic [31:0] POLY_REFL = 32'hEDB8_8320;
  localparam logic [31:0] CRC_SEED = 32'hFFFF_FFFF;
  localparam logic [20:0] CNT_SAT = 21'h1F_FFFF;
  // register slots past the last real register; writes there must do nothing
  localparam logic [biv_pkg::IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [biv_pkg::IDX_W-1:0] IDX_SPARE_HI = 3'd7;
  localparam int RANDOM_BEATS = 1650;

  typedef struct packed {
    biv_pkg::status_t status;
    logic [31:0]      crc;
    logic [31:0]      stack_word;
    logic [31:0]      entry_word;
  } verdict_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_wr_en = 1'b0;
  logic [biv_pkg::IDX_W-1:0]  cfg_index = '0;
  logic [biv_pkg::WORD_W-1:0] cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [7:0]                 in_data_byte = '0;
  logic                       in_last = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [2:0]                 out_status;
  logic [biv_pkg::WORD_W-1:0] out_computed_crc;
  logic [biv_pkg::WORD_W-1:0] out_stack_word;
  logic [biv_pkg::WORD_W-1:0] out_entry_word;

  // both sides throttle at random while this is set
  logic bursty = 1'b1;
  int   fault_count = 0;
  int   sent_beats = 0;

  // shadow of the register file
  logic [20:0] len_cfg = '0;
  logic [31:0] crc_cfg = '0;
  logic [31:0] stk_lo_cfg = '0;
  logic [31:0] stk_hi_cfg = '0;
  logic [31:0] app_cfg = '0;
  logic [31:0] manifest_cfg = '0;

  // shadow of the running image state
  logic [31:0] crc_acc = CRC_SEED;
  logic [20:0] byte_cnt = '0;
  logic [31:0] stack_cap = '0;
  logic [31:0] entry_cap = '0;

  verdict_t pending_verdicts[$];

  boot_image_verifier_unit #(
    .MAX_IMAGE_BYTES(IMAGE_MAX)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data_byte(in_data_byte),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_computed_crc(out_computed_crc),
    .out_stack_word(out_stack_word),
    .out_entry_word(out_entry_word)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow model
  // ---------------------------------------------------------------------------

  // LSB-first CRC-32: feed each data bit into the feedback tap in turn
  function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = {1'b0, c[31:1]} ^ (fb ? POLY_REFL : 32'h0);
    end
    return c;
  endfunction

  function automatic logic [31:0] image_crc(input logic [7:0] img[$]);
    logic [31:0] c;
    c = CRC_SEED;
    foreach (img[i]) c = crc32_step(c, img[i]);
    return c ^ CRC_SEED;
  endfunction

  // first failing check wins
  function automatic biv_pkg::status_t judge_image(input logic [31:0] crc);
    logic [31:0] addr;
    logic [32:0] app_end;
    if (len_cfg == 0 || len_cfg > IMAGE_MAX) return biv_pkg::ST_BAD_SIZE;
    if (byte_cnt != len_cfg) return biv_pkg::ST_LEN_MISM;
    if (crc != crc_cfg) return biv_pkg::ST_CRC_BAD;
    if (stack_cap < stk_lo_cfg || stack_cap > stk_hi_cfg || stack_cap[2:0] != 3'd0)
      return biv_pkg::ST_STACK_BAD;
    addr = {entry_cap[31:1], 1'b0};
    // app end is taken 33 bits wide: no wrap at the top of the address space
    app_end = {1'b0, app_cfg} + {12'd0, len_cfg};
    if (addr < app_cfg || {1'b0, addr} >= app_end || addr >= manifest_cfg || !entry_cap[0])
      return biv_pkg::ST_ENTRY_BAD;
    return biv_pkg::ST_OK;
  endfunction

  task automatic absorb_image_byte(input logic [7:0] b, input logic is_last);
    verdict_t v;
    logic [31:0] final_crc;
    // bytes 0..3 form the stack pointer, 4..7 the entry word, little-endian
    if (byte_cnt < 4)
      stack_cap = stack_cap | ({24'd0, b} << (8 * byte_cnt));
    else if (byte_cnt < 8)
      entry_cap = entry_cap | ({24'd0, b} << (8 * (byte_cnt - 4)));
    crc_acc = crc32_step(crc_acc, b);
    if (byte_cnt != CNT_SAT) byte_cnt = byte_cnt + 1'b1;
    if (is_last) begin
      final_crc = crc_acc ^ CRC_SEED;
      v.status = judge_image(final_crc);
      v.crc = final_crc;
      v.stack_word = stack_cap;
      v.entry_word = entry_cap;
      pending_verdicts.push_back(v);
      // image state starts over; registers stay
      crc_acc = CRC_SEED;
      byte_cnt = '0;
      stack_cap = '0;
      entry_cap = '0;
    end
  endtask

  // Every accepted image beat goes through the shadow.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) absorb_image_byte(in_data_byte, in_last);
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void flag_field(input string what, input logic [31:0] want,
                                     input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
      fault_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result beat with nothing expected: expected none, actual status %0d",
                 $time, out_status);
        fault_count++;
      end else begin
        want = pending_verdicts.pop_front();
        flag_field("status", {29'd0, want.status}, {29'd0, out_status});
        flag_field("computed_crc", want.crc, out_computed_crc);
        flag_field("stack_word", want.stack_word, out_stack_word);
        flag_field("entry_word", want.entry_word, out_entry_word);
      end
    end
  end

  // Result side back-pressure: about 30% of cycles while bursty is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= bursty && ($urandom_range(99) < 30);
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // One image byte; an optional idle gap goes ahead of it. Returns right after
  // the edge that took the beat.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    if (bursty && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last <= is_last;
    do @(posedge clk); while (in_stall);
    sent_beats++;
  endtask

  task automatic send_image(input logic [7:0] img[$]);
    foreach (img[i]) send_byte(img[i], i == img.size() - 1);
  endtask

  // Drain: all verdicts collected, then a few more cycles so the pipeline is
  // empty before registers change.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  // Leaves the write enable high; the caller drops it after its last write.
  task automatic write_reg(input logic [biv_pkg::IDX_W-1:0] idx, input logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      biv_pkg::REG_EXP_LEN:   len_cfg = val[20:0];
      biv_pkg::REG_EXP_CRC:   crc_cfg = val;
      biv_pkg::REG_STACK_LO:  stk_lo_cfg = val;
      biv_pkg::REG_STACK_HI:  stk_hi_cfg = val;
      biv_pkg::REG_APP_START: app_cfg = val;
      biv_pkg::REG_MANIFEST:  manifest_cfg = val;
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [31:0] len_word, input logic [31:0] crc,
                             input logic [31:0] lo, input logic [31:0] hi,
                             input logic [31:0] app, input logic [31:0] man);
    write_reg(biv_pkg::REG_EXP_LEN, len_word);
    write_reg(biv_pkg::REG_EXP_CRC, crc);
    write_reg(biv_pkg::REG_STACK_LO, lo);
    write_reg(biv_pkg::REG_STACK_HI, hi);
    write_reg(biv_pkg::REG_APP_START, app);
    write_reg(biv_pkg::REG_MANIFEST, man);
    cfg_wr_en <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Length register at zero (reset value), just past the max, all ones, and
  // exactly the max with a one-byte image.
  task automatic test_size_limits();
    logic [7:0] img[$];
    img = '{8'hFF};
    send_image(img);
    settle();
    load_config(IMAGE_MAX + 1, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    img = '{8'h00};
    send_image(img);
    settle();
    // upper bits of the write must be dropped by the 21-bit register
    load_config(32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    img = '{8'h5A};
    send_image(img);
    settle();
    load_config(IMAGE_MAX, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    img = '{8'hA5};
    send_image(img);
  endtask

  // Well-formed eight-byte image that must pass every check.
  task automatic test_good_image();
    logic [7:0] img[$];
    img = '{8'h00, 8'h80, 8'h00, 8'h20, 8'h05, 8'h00, 8'h00, 8'h08};
    settle();
    load_config(32'd8, image_crc(img), 32'h2000_0008, 32'h2002_0000,
                32'h0800_0000, 32'h0800_8000);
    send_image(img);
  endtask

  // Three-byte image: stack word only partly filled, entry word stays zero.
  // The spare register slots get values that would break the stack check if
  // they landed on a real register.
  task automatic test_short_image_spare_regs();
    logic [7:0] img[$];
    img = '{8'h08, 8'h11, 8'h22};
    settle();
    load_config(32'd3, image_crc(img), 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    @(posedge clk);
    write_reg(IDX_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(IDX_SPARE_HI, 32'h0);
    cfg_wr_en <= 1'b0;
    send_image(img);
  endtask

  // Application at the very top of the address space: base plus length
  // crosses 2^32 and must not wrap.
  task automatic test_entry_at_top();
    logic [7:0] img[$];
    img = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFD, 8'hFF, 8'hFF, 8'hFF};
    settle();
    load_config(32'd8, image_crc(img), 32'h0, 32'hFFFF_FFFF,
                32'hFFFF_FFF8, 32'hFFFF_FFFF);
    send_image(img);
  endtask

  // Mostly consistent images with random content and registers set to match,
  // about 30% with one thing broken, and some sent against stale registers
  // back to back.
  task automatic test_random_images();
    logic [7:0]  img[$];
    logic [31:0] stk, ent, lo, hi, app, man, crc, len_word, addr;
    int          len, pick, n, start, k;
    n = 0;
    start = sent_beats;
    while (sent_beats - start < RANDOM_BEATS) begin
      // one stretch of images with no throttling on either side
      bursty = !(n >= 40 && n < 60);
      pick = $urandom_range(99);
      if ($urandom_range(19) == 0) len = $urandom_range(9, 300);
      else if ($urandom_range(9) == 0) len = $urandom_range(1, 7);
      else len = $urandom_range(8, 24);

      stk = $urandom() & ~32'h7;
      lo = stk - $urandom_range(0, 4096);
      if (lo > stk) lo = 32'h0;
      hi = stk + $urandom_range(0, 4096);
      if (hi < stk) hi = 32'hFFFF_FFFF;
      app = ($urandom_range(15) == 0) ? 32'h0 : ($urandom() & ~32'h1);
      addr = (app + $urandom_range(0, len - 1)) & ~32'h1;
      ent = addr | 32'h1;
      man = addr + 1 + $urandom_range(0, 4096);
      if ($urandom_range(7) == 0) begin
        lo = 32'h0;
        hi = 32'hFFFF_FFFF;
        man = 32'hFFFF_FFFF;
      end

      img.delete();
      for (int i = 0; i < len; i++) img.push_back(8'($urandom_range(0, 255)));
      for (int i = 0; i < 4 && i < len; i++) img[i] = stk[8*i +: 8];
      for (int i = 4; i < 8 && i < len; i++) img[i] = ent[8*(i-4) +: 8];
      // junk above bit 20 of the length write
      len_word = $urandom();
      len_word[20:0] = 21'(len);
      crc = image_crc(img);

      if (pick < 30) begin
        case ($urandom_range(7))
          0: case ($urandom_range(3))
               0: len_word[20:0] = 21'd0;
               1: len_word[20:0] = 21'(IMAGE_MAX + 1);
               2: len_word[20:0] = CNT_SAT;
               default: len_word[20:0] = 21'($urandom_range(IMAGE_MAX + 1, CNT_SAT));
             endcase
          1: len_word[20:0] = 21'($urandom_range(1) ? len + 1 : len - 1);
          2: crc = crc ^ (32'h1 << $urandom_range(31));
          3: begin
            k = $urandom_range(0, len - 1);
            img[k] = img[k] ^ (8'h01 << $urandom_range(7));
          end
          4: begin
            img[0][2:0] = 3'($urandom_range(1, 7));
            crc = image_crc(img);
          end
          5: if ($urandom_range(1)) lo = stk + 8;
             else hi = stk - 8;
          6: if (len > 4) begin
            img[4][0] = 1'b0;
            crc = image_crc(img);
          end
          default: if ($urandom_range(1)) man = addr;
                   else app = addr + 2;
        endcase
      end

      // a tenth of the images reuse whatever registers are loaded
      if (!(pick >= 30 && pick < 40 && n > 0)) begin
        settle();
        load_config(len_word, crc, lo, hi, app, man);
      end
      send_image(img);
      n++;
    end
    bursty = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_size_limits();
    test_good_image();
    test_short_image_spare_regs();
    test_entry_at_top();
    test_random_images();
    settle();
    if (fault_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // hang guard: 20 ms is far past the slowest legal run
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
